// ===== src/hvt_pkg.sv =====
// constants and widths shared by the histogram valley threshold block
package hvt_pkg;

    localparam int COUNT_BITS = 16;
    localparam int NUM_BINS   = 256;
    localparam int BIN_BITS   = 8;
    localparam int IDX_BITS   = BIN_BITS + 1;

    // smoothing sum holds at most 9 full counts
    localparam int SUM_BITS   = COUNT_BITS + 4;
    localparam int RECIP_BITS = SUM_BITS - 2;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;

    localparam int SQ_BITS    = 2 * IDX_BITS;
    localparam int SCORE_BITS = SQ_BITS + COUNT_BITS;

    localparam logic [3:0] DIV_EDGE = 4'd6;
    localparam logic [3:0] DIV_NEAR = 4'd8;
    localparam logic [3:0] DIV_MID  = 4'd9;

    localparam logic [RECIP_BITS-1:0] RECIP_EDGE = RECIP_BITS'((64'd1 << SUM_BITS) / 6);
    localparam logic [RECIP_BITS-1:0] RECIP_NEAR = RECIP_BITS'((64'd1 << SUM_BITS) / 8);
    localparam logic [RECIP_BITS-1:0] RECIP_MID  = RECIP_BITS'((64'd1 << SUM_BITS) / 9);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IDX_BITS-1:0]   LAST_BIN  = IDX_BITS'(NUM_BINS - 1);
    localparam logic [IDX_BITS-1:0]   NO_BIN    = IDX_BITS'(NUM_BINS);

endpackage

// ===== src/histogram_valley_threshold.sv =====
// histogram valley threshold top level: bin store, smoothing, peak and valley search
//
// Pixels are taken one per cycle while the tile accumulates; counted pixels
// increment their bin through a read-modify-write on a 256-entry count memory,
// with a bypass so that equal bins on consecutive cycles add up correctly.
// The pixel that carries tlast closes the tile: input then stalls while the
// block smooths the store in place, scans for the second peak, walks the
// span between the peaks for the valley and clears the store. The finishing
// time of a tile is set by these passes over the count memory, one read and
// one write a cycle. After reset a clearing pass over all 256 bins runs
// before the first pixel is taken. The threshold waits in an output
// register, so the next tile may start before it is taken.
module histogram_valley_threshold (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel_value
    input  logic        s_axis_tuser,   // counted
    input  logic        s_axis_tlast,   // tile_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // threshold
);
    import hvt_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_ACC,
        ST_DRAIN,
        ST_LOAD,
        ST_SMOOTH,
        ST_KINIT,
        ST_PEAK,
        ST_VINIT,
        ST_VALLEY,
        ST_EMIT
    } t_state;

    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [COUNT_BITS-1:0] r_rdata;

    t_state                r_state;
    logic [IDX_BITS-1:0]   r_idx;
    logic [1:0]            r_ph;
    logic                  r_pass;

    logic                  r_s1_valid;
    logic [BIN_BITS-1:0]   r_s1_addr;
    logic                  r_byp_valid;
    logic [BIN_BITS-1:0]   r_byp_addr;
    logic [COUNT_BITS-1:0] r_byp_data;

    logic [COUNT_BITS-1:0] r_p1, r_p2, r_w0, r_w1, r_w2, r_next;
    logic [SUM_BITS-1:0]   r_sum;
    logic [PROD_BITS-1:0]  r_prod;
    logic [3:0]            r_div;

    logic [COUNT_BITS-1:0] r_max;
    logic [BIN_BITS-1:0]   r_j;
    logic [IDX_BITS-1:0]   r_k;
    logic                  r_kfound;
    logic [COUNT_BITS-1:0] r_hk;
    logic [SQ_BITS-1:0]    r_sq;
    logic [SCORE_BITS-1:0] r_cand;
    logic [SCORE_BITS-1:0] r_kscore;

    logic [BIN_BITS-1:0]   r_t;
    logic [COUNT_BITS-1:0] r_tval;

    logic                  r_out_valid;
    logic [BIN_BITS-1:0]   r_out_data;

    logic                  wr_en;
    logic [BIN_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [BIN_BITS-1:0]   rd_addr;

    logic                  in_acc;
    logic [COUNT_BITS-1:0] acc_cur;
    logic [COUNT_BITS-1:0] n_count;
    logic [SUM_BITS-1:0]   n_sum;
    logic [RECIP_BITS-1:0] recip_sel;
    logic [3:0]            div_sel;
    logic [RECIP_BITS-1:0] quot0;
    logic [SUM_BITS-1:0]   rem;
    logic [COUNT_BITS-1:0] n_quot;
    logic [IDX_BITS-1:0]   dist_src;
    logic [IDX_BITS-1:0]   bin_dist;
    logic [COUNT_BITS-1:0] score_h;
    logic [SCORE_BITS-1:0] n_score;
    logic [IDX_BITS-1:0]   idx_p2, idx_p3;
    logic [IDX_BITS-1:0]   lo_bin, hi_bin;
    logic                  is_lmax;

    assign s_axis_tready = (r_state == ST_ACC);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign idx_p2 = r_idx + IDX_BITS'(2);
    assign idx_p3 = r_idx + IDX_BITS'(3);

    // increment with bypass of the write made on the previous edge
    assign acc_cur = (r_byp_valid && r_byp_addr == r_s1_addr) ? r_byp_data : r_rdata;
    assign n_count = (acc_cur == COUNT_MAX) ? acc_cur : acc_cur + COUNT_BITS'(1);

    // smoothing kernel, out-of-range taps are zero in the window
    assign n_sum = SUM_BITS'(r_p2) + (SUM_BITS'(r_p1) << 1)
                 + SUM_BITS'(r_w0) + (SUM_BITS'(r_w0) << 1)
                 + (SUM_BITS'(r_w1) << 1) + SUM_BITS'(r_w2);

    always_comb begin
        if (r_idx == '0 || r_idx == LAST_BIN) begin
            div_sel   = DIV_EDGE;
            recip_sel = RECIP_EDGE;
        end else if (r_idx == IDX_BITS'(1) || r_idx == LAST_BIN - IDX_BITS'(1)) begin
            div_sel   = DIV_NEAR;
            recip_sel = RECIP_NEAR;
        end else begin
            div_sel   = DIV_MID;
            recip_sel = RECIP_MID;
        end
    end

    assign quot0  = r_prod[SUM_BITS +: RECIP_BITS];
    assign rem    = r_sum - SUM_BITS'(quot0) * SUM_BITS'(r_div);
    assign n_quot = (rem >= SUM_BITS'(r_div)) ? COUNT_BITS'(quot0 + RECIP_BITS'(1))
                                              : COUNT_BITS'(quot0);

    // squared distance and score for the second peak
    assign dist_src = (r_state == ST_KINIT) ? r_k : r_idx;
    assign bin_dist = (dist_src >= IDX_BITS'(r_j)) ? dist_src - IDX_BITS'(r_j)
                                                   : IDX_BITS'(r_j) - dist_src;
    assign score_h  = (r_state == ST_KINIT) ? r_hk : r_w1;
    assign n_score  = SCORE_BITS'(r_sq) * SCORE_BITS'(score_h);
    assign is_lmax  = (r_w1 != '0) && (r_w0 <= r_w1) && (r_w2 <= r_w1);

    assign lo_bin = (IDX_BITS'(r_j) < r_k) ? IDX_BITS'(r_j) : r_k;
    assign hi_bin = (IDX_BITS'(r_j) < r_k) ? r_k : IDX_BITS'(r_j);

    always_comb begin
        case (r_state)
            ST_ACC:    rd_addr = s_axis_tdata;
            ST_LOAD:   rd_addr = r_idx[BIN_BITS-1:0];
            ST_SMOOTH: rd_addr = idx_p3[BIN_BITS-1:0];
            ST_PEAK:   rd_addr = idx_p2[BIN_BITS-1:0];
            ST_VALLEY: rd_addr = r_idx[BIN_BITS-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[BIN_BITS-1:0];
        wr_data = '0;
        if (r_s1_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_s1_addr;
            wr_data = n_count;
        end else if (r_state == ST_SMOOTH && r_ph == 2'd2) begin
            wr_en   = 1'b1;
            wr_data = n_quot;
        end else if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_ph        <= '0;
            r_pass      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= in_acc && s_axis_tuser;
            r_s1_addr   <= s_axis_tdata;
            r_byp_valid <= r_s1_valid;
            r_byp_addr  <= r_s1_addr;
            r_byp_data  <= n_count;

            if (r_out_valid && m_axis_tready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    if (r_idx == LAST_BIN) begin
                        r_state <= ST_ACC;
                    end
                    r_idx <= r_idx + IDX_BITS'(1);
                end
                ST_ACC: begin
                    if (in_acc && s_axis_tlast) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state  <= ST_LOAD;
                    r_idx    <= '0;
                    r_pass   <= 1'b0;
                    r_p1     <= '0;
                    r_p2     <= '0;
                    r_max    <= '0;
                    r_j      <= '0;
                    r_k      <= NO_BIN;
                    r_kfound <= 1'b0;
                    r_hk     <= '0;
                end
                ST_LOAD: begin
                    if (r_idx != '0) begin
                        r_w0 <= r_w1;
                        r_w1 <= r_w2;
                        r_w2 <= r_rdata;
                    end
                    if (r_idx == IDX_BITS'(3)) begin
                        r_ph <= '0;
                        if (!r_pass) begin
                            r_state <= ST_SMOOTH;
                            r_idx   <= '0;
                        end else begin
                            r_state <= ST_KINIT;
                        end
                    end else begin
                        r_idx <= r_idx + IDX_BITS'(1);
                    end
                end
                ST_SMOOTH: begin
                    case (r_ph)
                        2'd0: begin
                            r_sum <= n_sum;
                            r_ph  <= 2'd1;
                        end
                        2'd1: begin
                            r_prod <= PROD_BITS'(r_sum) * PROD_BITS'(recip_sel);
                            r_div  <= div_sel;
                            r_next <= (idx_p3 < NO_BIN) ? r_rdata : '0;
                            r_ph   <= 2'd2;
                        end
                        default: begin
                            r_p2 <= r_p1;
                            r_p1 <= n_quot;
                            r_w0 <= r_w1;
                            r_w1 <= r_w2;
                            r_w2 <= r_next;
                            if (n_quot > r_max) begin
                                r_max <= n_quot;
                                r_j   <= r_idx[BIN_BITS-1:0];
                            end
                            if (!r_kfound && n_quot != '0) begin
                                r_kfound <= 1'b1;
                                r_k      <= r_idx;
                                r_hk     <= n_quot;
                            end
                            r_ph <= 2'd0;
                            if (r_idx == LAST_BIN) begin
                                r_state <= ST_LOAD;
                                r_pass  <= 1'b1;
                                r_idx   <= '0;
                            end else begin
                                r_idx <= r_idx + IDX_BITS'(1);
                            end
                        end
                    endcase
                end
                ST_KINIT: begin
                    if (r_ph == 2'd0) begin
                        r_sq <= SQ_BITS'(bin_dist) * SQ_BITS'(bin_dist);
                        r_ph <= 2'd1;
                    end else begin
                        r_kscore <= n_score;
                        r_ph     <= 2'd0;
                        r_idx    <= IDX_BITS'(1);
                        r_state  <= ST_PEAK;
                    end
                end
                ST_PEAK: begin
                    case (r_ph)
                        2'd0: begin
                            r_sq <= SQ_BITS'(bin_dist) * SQ_BITS'(bin_dist);
                            r_ph <= 2'd1;
                        end
                        2'd1: begin
                            r_cand <= n_score;
                            r_next <= (idx_p2 < NO_BIN) ? r_rdata : '0;
                            r_ph   <= 2'd2;
                        end
                        default: begin
                            if (is_lmax && r_kscore < r_cand) begin
                                r_k      <= r_idx;
                                r_kscore <= r_cand;
                            end
                            r_w0 <= r_w1;
                            r_w1 <= r_w2;
                            r_w2 <= r_next;
                            r_ph <= 2'd0;
                            if (r_idx == LAST_BIN) begin
                                r_state <= ST_VINIT;
                            end else begin
                                r_idx <= r_idx + IDX_BITS'(1);
                            end
                        end
                    endcase
                end
                ST_VINIT: begin
                    r_idx   <= lo_bin;
                    r_t     <= r_j;
                    r_tval  <= r_max;
                    r_ph    <= 2'd0;
                    r_state <= ST_VALLEY;
                end
                ST_VALLEY: begin
                    if (r_ph == 2'd0) begin
                        if (r_idx >= hi_bin) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_ph <= 2'd1;
                        end
                    end else begin
                        if (r_rdata != '0 && r_rdata < r_tval) begin
                            r_t    <= r_idx[BIN_BITS-1:0];
                            r_tval <= r_rdata;
                        end
                        r_idx <= r_idx + IDX_BITS'(1);
                        r_ph  <= 2'd0;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_t;
                        r_idx       <= '0;
                        r_state     <= ST_CLEAR;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                    r_idx   <= '0;
                end
            endcase
        end
    end

endmodule
